// File: src/clsw_pkg.sv
`default_nettype none
package clsw_pkg;

  localparam int unsigned DEFAULT_VALUE_WIDTH = 16;
  localparam int unsigned QUEUE_DEPTH         = 2;
  localparam int unsigned QUEUE_PTR_W         = $clog2(QUEUE_DEPTH);
  localparam int unsigned CFG_INDEX_W         = 3;
  localparam int unsigned CFG_DATA_W          = 30;

  typedef enum logic [1:0] {
    KIND_RATE     = 2'd0,
    KIND_ATTITUDE = 2'd1,
    KIND_TICK     = 2'd2
  } in_kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_OUTPUT_MODE   = 3'd0,
    REG_MAX_RATE      = 3'd1,
    REG_INV_SCALE     = 3'd2,
    REG_THRUST_FLOOR  = 3'd3,
    REG_THRUST_CEIL   = 3'd4,
    REG_THRUST_STEP   = 3'd5,
    REG_YAW_STEP      = 3'd6,
    REG_TIMEOUT_LIMIT = 3'd7
  } cfg_index_t;

  localparam logic        RESULT_COMMAND   = 1'b0;
  localparam logic        RESULT_SAFE_IDLE = 1'b1;

  localparam logic [1:0]  MODE_BODY_RATES   = 2'd0;
  localparam logic [1:0]  MODE_RC           = 2'd1;

  localparam logic [1:0]  MODE_RESET        = 2'd0;
  localparam logic [14:0] MAX_RATE_RESET    = 15'd2560;
  localparam logic [29:0] INV_SCALE_RESET   = 30'd419430;
  localparam logic [15:0] THRUST_FLOOR_RST  = 16'd3277;
  localparam logic [15:0] THRUST_CEIL_RST   = 16'd58982;
  localparam logic [15:0] THRUST_STEP_RST   = 16'd1966;
  localparam logic [14:0] YAW_STEP_RESET    = 15'd13;
  localparam logic [15:0] TIMEOUT_RESET     = 16'd200;

  localparam logic [16:0] QUIET_MAX         = 17'h1FFFF;
  localparam logic [15:0] PHASE_MAX         = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  output_mode;
    logic [14:0] max_rate;
    logic [29:0] inv_scale;
    logic [15:0] thrust_floor;
    logic [15:0] thrust_ceiling;
    logic [15:0] thrust_step;
    logic [14:0] yaw_step;
    logic [15:0] timeout_limit;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic               fmt;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic [15:0]        thrust;
  } cmd_t;

endpackage
`default_nettype wire

// File: src/clsw_cfg_regs.sv
`default_nettype none
module clsw_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [clsw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [clsw_pkg::CFG_DATA_W-1:0]  cfg_data,
  output clsw_pkg::cfg_t                        cfg
);

  clsw_pkg::cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (clsw_pkg::cfg_index_t'(cfg_index))
        clsw_pkg::REG_OUTPUT_MODE:   cfg_nxt.output_mode    = cfg_data[1:0];
        clsw_pkg::REG_MAX_RATE:      cfg_nxt.max_rate       = cfg_data[14:0];
        clsw_pkg::REG_INV_SCALE:     cfg_nxt.inv_scale      = cfg_data[29:0];
        clsw_pkg::REG_THRUST_FLOOR:  cfg_nxt.thrust_floor   = cfg_data[15:0];
        clsw_pkg::REG_THRUST_CEIL:   cfg_nxt.thrust_ceiling = cfg_data[15:0];
        clsw_pkg::REG_THRUST_STEP:   cfg_nxt.thrust_step    = cfg_data[15:0];
        clsw_pkg::REG_YAW_STEP:      cfg_nxt.yaw_step       = cfg_data[14:0];
        clsw_pkg::REG_TIMEOUT_LIMIT: cfg_nxt.timeout_limit  = cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.output_mode    <= clsw_pkg::MODE_RESET;
      cfg_r.max_rate       <= clsw_pkg::MAX_RATE_RESET;
      cfg_r.inv_scale      <= clsw_pkg::INV_SCALE_RESET;
      cfg_r.thrust_floor   <= clsw_pkg::THRUST_FLOOR_RST;
      cfg_r.thrust_ceiling <= clsw_pkg::THRUST_CEIL_RST;
      cfg_r.thrust_step    <= clsw_pkg::THRUST_STEP_RST;
      cfg_r.yaw_step       <= clsw_pkg::YAW_STEP_RESET;
      cfg_r.timeout_limit  <= clsw_pkg::TIMEOUT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/clsw_front.sv
`default_nettype none
module clsw_front #(
  parameter int unsigned VALUE_WIDTH = clsw_pkg::DEFAULT_VALUE_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  clsw_pkg::cfg_t                     cfg,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_kind,
  input  wire logic signed [VALUE_WIDTH-1:0] in_rate_x,
  input  wire logic signed [VALUE_WIDTH-1:0] in_rate_y,
  input  wire logic signed [VALUE_WIDTH-1:0] in_rate_z,
  input  wire logic [VALUE_WIDTH-1:0]        in_thrust_in,
  input  wire logic                          q_full,
  output logic                               q_push,
  output clsw_pkg::cmd_t                     q_entry
);

  localparam int unsigned CW = ((VALUE_WIDTH > 16) ? VALUE_WIDTH : 16) + 2;
  localparam bit THR_SIGNED = (VALUE_WIDTH >= 32);

  logic [15:0]        held_thrust_r, held_thrust_nxt;
  logic signed [15:0] held_yaw_r, held_yaw_nxt;
  logic               seen_r, seen_nxt;
  logic [16:0]        quiet_r, quiet_nxt;
  logic [15:0]        phase_r, phase_nxt;

  logic               accept;
  logic               emit_ok;
  logic signed [15:0] x_c, y_c, z_c, z_sl;
  logic signed [CW-1:0] t_in, t_flo, t_cei, t_1, t_2;
  logic [15:0]        t_c, t_sl;
  logic signed [17:0] t_d, t_st, t_dc, t_sum;
  logic signed [17:0] z_d, z_st, z_dc, z_sum;
  logic [15:0]        period;
  logic [16:0]        quiet_inc;
  logic [15:0]        phase_inc;

  function automatic logic signed [15:0] clamp_rate(input logic signed [VALUE_WIDTH-1:0] v,
                                                    input logic [14:0] lim);
    logic signed [CW-1:0] ve;
    logic signed [CW-1:0] le;
    logic signed [CW-1:0] res;
    ve = CW'(v);
    le = CW'(signed'({1'b0, lim}));
    res = ve;
    if (ve < -le) res = -le;
    if (ve > le) res = le;
    return res[15:0];
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign emit_ok  = cfg.output_mode inside {clsw_pkg::MODE_BODY_RATES, clsw_pkg::MODE_RC};

  always_comb begin
    x_c = '0;
    y_c = '0;
    z_c = '0;
    if (in_kind == clsw_pkg::KIND_RATE) begin
      x_c = clamp_rate(in_rate_x, cfg.max_rate);
      y_c = clamp_rate(in_rate_y, cfg.max_rate);
      z_c = clamp_rate(in_rate_z, cfg.max_rate);
    end

    t_in  = CW'(signed'({in_thrust_in[VALUE_WIDTH-1] & THR_SIGNED, in_thrust_in}));
    t_flo = CW'(signed'({1'b0, cfg.thrust_floor}));
    t_cei = CW'(signed'({1'b0, cfg.thrust_ceiling}));
    t_1   = (t_in < t_flo) ? t_flo : t_in;
    t_2   = (t_1 > t_cei) ? t_cei : t_1;
    t_c   = t_2[15:0];

    t_d  = signed'({2'b00, t_c}) - signed'({2'b00, held_thrust_r});
    t_st = signed'({2'b00, cfg.thrust_step});
    t_dc = t_d;
    if (t_d < -t_st) t_dc = -t_st;
    if (t_d > t_st) t_dc = t_st;
    t_sum = signed'({2'b00, held_thrust_r}) + t_dc;
    t_sl  = seen_r ? t_sum[15:0] : t_c;

    z_d  = signed'({{2{z_c[15]}}, z_c}) - signed'({{2{held_yaw_r[15]}}, held_yaw_r});
    z_st = signed'({3'b000, cfg.yaw_step});
    z_dc = z_d;
    if (z_d < -z_st) z_dc = -z_st;
    if (z_d > z_st) z_dc = z_st;
    z_sum = signed'({{2{held_yaw_r[15]}}, held_yaw_r}) + z_dc;
    z_sl  = seen_r ? z_sum[15:0] : z_c;

    period    = (cfg.timeout_limit >> 1) == 16'd0 ? 16'd1 : (cfg.timeout_limit >> 1);
    quiet_inc = (quiet_r == clsw_pkg::QUIET_MAX) ? quiet_r : quiet_r + 17'd1;
    phase_inc = (phase_r == clsw_pkg::PHASE_MAX) ? phase_r : phase_r + 16'd1;
  end

  always_comb begin
    held_thrust_nxt = held_thrust_r;
    held_yaw_nxt    = held_yaw_r;
    seen_nxt        = seen_r;
    quiet_nxt       = quiet_r;
    phase_nxt       = phase_r;
    q_push          = 1'b0;
    q_entry         = '0;
    q_entry.fmt     = cfg.output_mode[0];
    if (accept) begin
      case (in_kind)
        clsw_pkg::KIND_RATE, clsw_pkg::KIND_ATTITUDE: begin
          held_thrust_nxt = t_sl;
          held_yaw_nxt    = z_sl;
          seen_nxt        = 1'b1;
          quiet_nxt       = '0;
          q_push          = emit_ok;
          q_entry.kind    = clsw_pkg::RESULT_COMMAND;
          q_entry.roll    = x_c;
          q_entry.pitch   = y_c;
          q_entry.yaw     = z_sl;
          q_entry.thrust  = t_sl;
        end
        clsw_pkg::KIND_TICK: begin
          quiet_nxt = quiet_inc;
          phase_nxt = phase_inc;
          if (phase_inc >= period) begin
            phase_nxt = '0;
            if (quiet_inc > {1'b0, cfg.timeout_limit}) begin
              held_thrust_nxt = '0;
              held_yaw_nxt    = '0;
              q_push          = emit_ok;
              q_entry.kind    = clsw_pkg::RESULT_SAFE_IDLE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_thrust_r <= '0;
      held_yaw_r    <= '0;
      seen_r        <= 1'b0;
      quiet_r       <= '0;
      phase_r       <= '0;
    end else begin
      held_thrust_r <= held_thrust_nxt;
      held_yaw_r    <= held_yaw_nxt;
      seen_r        <= seen_nxt;
      quiet_r       <= quiet_nxt;
      phase_r       <= phase_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/clsw_queue.sv
`default_nettype none
module clsw_queue (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  clsw_pkg::cmd_t push_entry,
  output logic           full,
  input  wire logic      pop_ready,
  output logic           pop_valid,
  output clsw_pkg::cmd_t pop_entry
);

  localparam int unsigned CNT_W = $clog2(clsw_pkg::QUEUE_DEPTH + 1);

  clsw_pkg::cmd_t                  slot_r [clsw_pkg::QUEUE_DEPTH];
  logic [clsw_pkg::QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [clsw_pkg::QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic                            pop;

  assign full      = (count_r == CNT_W'(clsw_pkg::QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_entry = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == clsw_pkg::QUEUE_PTR_W'(clsw_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == clsw_pkg::QUEUE_PTR_W'(clsw_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(clsw_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not advance on push");
`endif

endmodule
`default_nettype wire

// File: src/clsw_back.sv
`default_nettype none
module clsw_back #(
  parameter int unsigned VALUE_WIDTH = clsw_pkg::DEFAULT_VALUE_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [29:0]            inv_scale,
  input  wire logic                   pop_valid,
  output logic                        pop_ready,
  input  clsw_pkg::cmd_t              pop_entry,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_result_kind,
  output logic                        out_result_format,
  output logic signed [VALUE_WIDTH-1:0] out_roll_out,
  output logic signed [VALUE_WIDTH-1:0] out_pitch_out,
  output logic signed [VALUE_WIDTH-1:0] out_yaw_out,
  output logic [VALUE_WIDTH-1:0]      out_thrust_out
);

  localparam logic signed [47:0] UNITY = 48'sd1 <<< (VALUE_WIDTH - 2);

  logic               a_valid_r;
  clsw_pkg::cmd_t     a_cmd_r;
  logic signed [46:0] a_px_r, a_py_r, a_pz_r;
  logic               b_valid_r;
  logic               b_kind_r, b_fmt_r;
  logic signed [VALUE_WIDTH-1:0] b_roll_r, b_pitch_r, b_yaw_r;
  logic [VALUE_WIDTH-1:0]        b_thrust_r;

  logic               b_free, a_adv, a_free;
  logic signed [30:0] inv_s;
  logic signed [VALUE_WIDTH-1:0] roll_nxt, pitch_nxt, yaw_nxt;
  logic [VALUE_WIDTH+15:0]       thrust_ext;

  function automatic logic signed [VALUE_WIDTH-1:0] rc_norm(input logic signed [46:0] p);
    logic signed [46:0] sh;
    logic signed [46:0] res;
    sh  = p >>> VALUE_WIDTH;
    res = sh;
    if (sh > UNITY) res = UNITY[46:0];
    if (sh < -UNITY) res = -UNITY[46:0];
    return res[VALUE_WIDTH-1:0];
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] body(input logic signed [15:0] v);
    logic [VALUE_WIDTH+15:0] e;
    e = {{VALUE_WIDTH{v[15]}}, v};
    return e[VALUE_WIDTH-1:0];
  endfunction

  assign b_free    = !b_valid_r || out_ready;
  assign a_adv     = a_valid_r && b_free;
  assign a_free    = !a_valid_r || a_adv;
  assign pop_ready = a_free;
  assign inv_s     = signed'({1'b0, inv_scale});

  always_comb begin
    if (a_cmd_r.fmt) begin
      roll_nxt  = rc_norm(a_px_r);
      pitch_nxt = rc_norm(a_py_r);
      yaw_nxt   = rc_norm(a_pz_r);
    end else begin
      roll_nxt  = body(a_cmd_r.roll);
      pitch_nxt = body(a_cmd_r.pitch);
      yaw_nxt   = body(a_cmd_r.yaw);
    end
    thrust_ext = {{VALUE_WIDTH{1'b0}}, a_cmd_r.thrust};
  end

  always_ff @(posedge clk) begin
    if (pop_valid && a_free) begin
      a_cmd_r <= pop_entry;
      a_px_r  <= pop_entry.roll * inv_s;
      a_py_r  <= pop_entry.pitch * inv_s;
      a_pz_r  <= pop_entry.yaw * inv_s;
    end
    if (a_adv) begin
      b_kind_r   <= a_cmd_r.kind;
      b_fmt_r    <= a_cmd_r.fmt;
      b_roll_r   <= roll_nxt;
      b_pitch_r  <= pitch_nxt;
      b_yaw_r    <= yaw_nxt;
      b_thrust_r <= thrust_ext[VALUE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_free) a_valid_r <= pop_valid;
      if (b_free) b_valid_r <= a_adv;
    end
  end

  assign out_valid         = b_valid_r;
  assign out_result_kind   = b_kind_r;
  assign out_result_format = b_fmt_r;
  assign out_roll_out      = b_roll_r;
  assign out_pitch_out     = b_pitch_r;
  assign out_yaw_out       = b_yaw_r;
  assign out_thrust_out    = b_thrust_r;

`ifndef SYNTH
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !out_ready) |=> (b_valid_r && $stable(b_roll_r) && $stable(b_thrust_r)))
    else $error("output beat changed while stalled");
  a_stage_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !b_free) |=> a_valid_r)
    else $error("multiply stage lost a beat");
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && b_kind_r) |-> (b_roll_r == '0 && b_yaw_r == '0 && b_thrust_r == '0))
    else $error("safe idle beat carries data");
`endif

endmodule
`default_nettype wire

// File: src/command_limiter_slew_watchdog_top.sv
// Channel  Handshake             Payload
// in       in_valid / in_ready   in_kind, in_rate_x/y/z, in_thrust_in
// out      out_valid / out_ready out_result_kind, out_result_format, out_*_out
// cfg      cfg_valid / cfg_ready cfg_index (3 bits), cfg_data (30 bits)
//
// One beat per cycle in and out unless stalled; the front updates limiter and
// watchdog state in the cycle a beat is accepted, so each beat sees the state its
// predecessor left. Path: queue slot, multiply stage (rc scaling), output register.
// in_ready drops only while the two-entry queue is full; cfg_ready is always high.
// Reset is synchronous, active low, and restores register defaults at once.
`default_nettype none
module command_limiter_slew_watchdog_top #(
  parameter int unsigned VALUE_WIDTH = clsw_pkg::DEFAULT_VALUE_WIDTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       in_kind,
  input  wire logic signed [VALUE_WIDTH-1:0]    in_rate_x,
  input  wire logic signed [VALUE_WIDTH-1:0]    in_rate_y,
  input  wire logic signed [VALUE_WIDTH-1:0]    in_rate_z,
  input  wire logic [VALUE_WIDTH-1:0]           in_thrust_in,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_result_kind,
  output logic                                  out_result_format,
  output logic signed [VALUE_WIDTH-1:0]         out_roll_out,
  output logic signed [VALUE_WIDTH-1:0]         out_pitch_out,
  output logic signed [VALUE_WIDTH-1:0]         out_yaw_out,
  output logic [VALUE_WIDTH-1:0]                out_thrust_out,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [clsw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [clsw_pkg::CFG_DATA_W-1:0]  cfg_data
);

  clsw_pkg::cfg_t cfg;
  clsw_pkg::cmd_t q_entry, pop_entry;
  logic           q_full, q_push, pop_valid, pop_ready;

  clsw_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  clsw_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_rate_x    (in_rate_x),
    .in_rate_y    (in_rate_y),
    .in_rate_z    (in_rate_z),
    .in_thrust_in (in_thrust_in),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  clsw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop_ready  (pop_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry)
  );

  clsw_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .inv_scale         (cfg.inv_scale),
    .pop_valid         (pop_valid),
    .pop_ready         (pop_ready),
    .pop_entry         (pop_entry),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_kind   (out_result_kind),
    .out_result_format (out_result_format),
    .out_roll_out      (out_roll_out),
    .out_pitch_out     (out_pitch_out),
    .out_yaw_out       (out_yaw_out),
    .out_thrust_out    (out_thrust_out)
  );

endmodule
`default_nettype wire
